// File: src/emr_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer.
// Used by the front, queue, back end and top level. No dependencies.
`default_nettype none

package emr_pkg;

  localparam int AXIS_WIDTH_DEF = 8;
  localparam int CENTER_W       = 10;
  localparam int PIX_W          = 12;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CENTER_W-1:0] CENTER_X_RST = 10'd300;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 10'd240;

  typedef enum logic {
    REG_CENTER_X = 1'b0,
    REG_CENTER_Y = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_ADVANCE = 1'b1
  } mode_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_LD_AA,
    BK_LD_BB,
    BK_LD_AB,
    BK_LD_DEC,
    BK_MUL_AY,
    BK_MUL_BX,
    BK_DECIDE,
    BK_STEP1,
    BK_ENT_XX,
    BK_ENT_YY,
    BK_ENT_BT,
    BK_ENT_AU,
    BK_ENT_AB,
    BK_ENT_SUM,
    BK_STEP2,
    BK_EMIT
  } bk_state_t;

endpackage

`default_nettype wire

// File: src/emr_front.sv
// Input stage: registers and classifies incoming transactions, pushes commands to the queue.
// Depends on emr_pkg.
`default_nettype none

module emr_front
  import emr_pkg::*;
#(
  parameter int AXIS_W = AXIS_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire logic [AXIS_W-1:0]     in_semi_axis_x,
  input  wire logic [AXIS_W-1:0]     in_semi_axis_y,
  input  wire q_status_t             q_status,
  output logic                       q_push,
  output logic [2*AXIS_W:0]          q_data
);

  localparam int CMD_W = 2*AXIS_W + 1;

  logic             hold_valid_r;
  logic             hold_valid_nxt;
  logic [CMD_W-1:0] hold_data_r;
  logic [CMD_W-1:0] cmd_nxt;
  logic             accept;

  assign in_stall = hold_valid_r & q_status.full;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = hold_valid_r & ~q_status.full;
  assign q_data   = hold_data_r;

  // advance commands carry no axes
  always_comb begin
    if (mode_t'(in_mode) == MODE_START) begin
      cmd_nxt = {in_mode, in_semi_axis_x, in_semi_axis_y};
    end else begin
      cmd_nxt = {in_mode, {(2*AXIS_W){1'b0}}};
    end
  end

  assign hold_valid_nxt = accept | (hold_valid_r & q_status.full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_data_r <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/emr_queue.sv
// Short command queue between front and back end.
// Depends on emr_pkg.
`default_nettype none

module emr_queue
  import emr_pkg::*;
#(
  parameter int DATA_W = 2*AXIS_WIDTH_DEF + 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output q_status_t              status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign pop_data     = entry_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end else begin
      return p + PTR_W'(1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/emr_back.sv
// Back end: sequencer around one shared multiplier that runs the midpoint
// ellipse steps and emits four mirrored pixels per step. Depends on emr_pkg.
`default_nettype none

module emr_back
  import emr_pkg::*;
#(
  parameter int AXIS_W = AXIS_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire q_status_t                q_status,
  output logic                          q_pop,
  input  wire logic [2*AXIS_W:0]        q_data,
  input  wire logic [CENTER_W-1:0]      center_x,
  input  wire logic [CENTER_W-1:0]      center_y,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [PIX_W-1:0]       out_pixel_x,
  output logic signed [PIX_W-1:0]       out_pixel_y,
  output logic                          out_last,
  output logic                          out_finished
);

  localparam int POS_W  = AXIS_W + 1;
  localparam int SQ_W   = 2*AXIS_W + 3;
  localparam int OPA_W  = 2*AXIS_W;
  localparam int OPB_W  = SQ_W;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int CMP_W  = 3*AXIS_W + 1;
  localparam int DEC_W  = 4*AXIS_W + 8;
  localparam int EXT_W  = (POS_W > PIX_W) ? POS_W : PIX_W;

  bk_state_t state_r, state_nxt;

  logic [AXIS_W-1:0] axis_a_r, axis_b_r;
  logic [OPA_W-1:0]  aa_r, bb_r;
  logic [POS_W-1:0]  pos_x_r, pos_y_r;
  logic [DEC_W-1:0]  dec_r, acc_r;
  logic [CMP_W-1:0]  aay_r, bbx_r;
  logic [SQ_W-1:0]   sq_r;
  logic [PROD_W-1:0] prod_r;
  logic              region2_r;
  logic              active_r;
  logic              out_valid_r;
  logic [1:0]        emit_idx_r;
  logic signed [PIX_W-1:0] pix_x_r, pix_y_r;
  logic              last_r, fin_r;

  logic [OPA_W-1:0]  mul_a;
  logic [OPB_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              emit_load;

  mode_t             cmd_mode;
  logic [AXIS_W-1:0] cmd_a, cmd_b;

  logic [POS_W-1:0]  ym_mag;
  logic              le1, ge2;
  logic [DEC_W-1:0]  step1_dec, step2_dec;
  logic [EXT_W-1:0]  sum_x, sum_y;

  assign cmd_mode = mode_t'(q_data[2*AXIS_W]);
  assign cmd_a    = q_data[2*AXIS_W-1:AXIS_W];
  assign cmd_b    = q_data[AXIS_W-1:0];

  assign ym_mag = (pos_y_r == '0) ? POS_W'(1) : pos_y_r - POS_W'(1);
  assign mul_p  = mul_a * mul_b;

  assign le1 = $signed(dec_r) <= $signed(DEC_W'(aa_r));
  assign ge2 = $signed(dec_r) >= $signed(DEC_W'(bb_r));

  // region one: d += 8bbx + 12bb, minus 8aa(y-1) when y steps
  assign step1_dec = dec_r + (DEC_W'(bbx_r) << 3) + (DEC_W'(bb_r) << 3)
                   + (DEC_W'(bb_r) << 2)
                   - (le1 ? '0 : ((DEC_W'(aay_r) << 3) - (DEC_W'(aa_r) << 3)));

  // region two: d += 12aa - 8aay, plus 8bb(x+1) when x steps
  assign step2_dec = dec_r + (DEC_W'(aa_r) << 3) + (DEC_W'(aa_r) << 2)
                   - (DEC_W'(aay_r) << 3)
                   + (ge2 ? '0 : ((DEC_W'(bbx_r) << 3) + (DEC_W'(bb_r) << 3)));

  // emit order: (+x,-y) (-x,-y) (+x,+y) (-x,+y)
  assign sum_x = emit_idx_r[0] ? EXT_W'(center_x) - EXT_W'(pos_x_r)
                               : EXT_W'(center_x) + EXT_W'(pos_x_r);
  assign sum_y = emit_idx_r[1] ? EXT_W'(center_y) + EXT_W'(pos_y_r)
                               : EXT_W'(center_y) - EXT_W'(pos_y_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          if (cmd_mode == MODE_START) begin
            state_nxt = BK_LD_AA;
          end else if (active_r) begin
            state_nxt = BK_MUL_AY;
          end
        end
      end
      BK_LD_AA:   state_nxt = BK_LD_BB;
      BK_LD_BB:   state_nxt = BK_LD_AB;
      BK_LD_AB:   state_nxt = BK_LD_DEC;
      BK_LD_DEC:  state_nxt = BK_EMIT;
      BK_MUL_AY:  state_nxt = BK_MUL_BX;
      BK_MUL_BX:  state_nxt = BK_DECIDE;
      BK_DECIDE: begin
        priority if (region2_r) begin
          state_nxt = BK_STEP2;
        end else if (aay_r >= prod_r[CMP_W-1:0]) begin
          state_nxt = BK_STEP1;
        end else begin
          state_nxt = BK_ENT_XX;
        end
      end
      BK_STEP1:   state_nxt = BK_EMIT;
      BK_ENT_XX:  state_nxt = BK_ENT_YY;
      BK_ENT_YY:  state_nxt = BK_ENT_BT;
      BK_ENT_BT:  state_nxt = BK_ENT_AU;
      BK_ENT_AU:  state_nxt = BK_ENT_AB;
      BK_ENT_AB:  state_nxt = BK_ENT_SUM;
      BK_ENT_SUM: state_nxt = BK_STEP2;
      BK_STEP2:   state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (emit_load && emit_idx_r == 2'd3) begin
          state_nxt = BK_IDLE;
        end
      end
      default:    state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    emit_load = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      BK_IDLE:   q_pop = ~q_status.empty;
      BK_LD_AA: begin
        mul_a = OPA_W'(axis_a_r);
        mul_b = OPB_W'(axis_a_r);
      end
      BK_LD_BB: begin
        mul_a = OPA_W'(axis_b_r);
        mul_b = OPB_W'(axis_b_r);
      end
      BK_LD_AB: begin
        mul_a = aa_r;
        mul_b = OPB_W'(axis_b_r);
      end
      BK_MUL_AY: begin
        mul_a = aa_r;
        mul_b = OPB_W'(pos_y_r);
      end
      BK_MUL_BX: begin
        mul_a = bb_r;
        mul_b = OPB_W'(pos_x_r);
      end
      BK_ENT_XX: begin
        mul_a = OPA_W'(pos_x_r);
        mul_b = OPB_W'(pos_x_r);
      end
      BK_ENT_YY: begin
        mul_a = OPA_W'(ym_mag);
        mul_b = OPB_W'(ym_mag);
      end
      BK_ENT_BT: begin
        mul_a = bb_r;
        mul_b = sq_r;
      end
      BK_ENT_AU: begin
        mul_a = aa_r;
        mul_b = sq_r;
      end
      BK_ENT_AB: begin
        mul_a = aa_r;
        mul_b = OPB_W'(bb_r);
      end
      BK_EMIT:   emit_load = ~out_valid_r | ~out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      active_r    <= 1'b0;
      region2_r   <= 1'b0;
      out_valid_r <= 1'b0;
      emit_idx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && cmd_mode == MODE_START) begin
        active_r  <= 1'b1;
        region2_r <= 1'b0;
      end
      if (state_r == BK_ENT_SUM) begin
        region2_r <= 1'b1;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
        emit_idx_r  <= emit_idx_r + 2'd1;
        if (emit_idx_r == 2'd3) begin
          active_r <= |pos_y_r;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    unique case (state_r)
      BK_IDLE: begin
        if (q_pop && cmd_mode == MODE_START) begin
          axis_a_r <= cmd_a;
          axis_b_r <= cmd_b;
          pos_x_r  <= '0;
          pos_y_r  <= POS_W'(cmd_b);
        end
      end
      BK_LD_BB:  aa_r <= prod_r[OPA_W-1:0];
      BK_LD_AB:  bb_r <= prod_r[OPA_W-1:0];
      BK_LD_DEC: begin
        dec_r <= (DEC_W'(bb_r) << 2) + (DEC_W'(aa_r) << 1) - (DEC_W'(prod_r) << 2);
      end
      BK_MUL_BX: aay_r <= prod_r[CMP_W-1:0];
      BK_DECIDE: bbx_r <= prod_r[CMP_W-1:0];
      BK_STEP1: begin
        dec_r   <= step1_dec;
        pos_x_r <= pos_x_r + POS_W'(1);
        if (!le1) begin
          pos_y_r <= pos_y_r - POS_W'(1);
        end
      end
      // x^2 + (x+1)^2 = 2x^2 + 2x + 1
      BK_ENT_YY: begin
        sq_r <= {prod_r[SQ_W-2:0], 1'b0} + SQ_W'({pos_x_r, 1'b0}) + SQ_W'(1);
      end
      BK_ENT_BT: sq_r  <= prod_r[SQ_W-1:0];
      BK_ENT_AU: acc_r <= DEC_W'(prod_r) << 1;
      BK_ENT_AB: acc_r <= acc_r + (DEC_W'(prod_r) << 2);
      BK_ENT_SUM: dec_r <= acc_r - (DEC_W'(prod_r) << 2);
      BK_STEP2: begin
        dec_r   <= step2_dec;
        pos_y_r <= pos_y_r - POS_W'(1);
        if (!ge2) begin
          pos_x_r <= pos_x_r + POS_W'(1);
        end
      end
      BK_EMIT: begin
        if (emit_load) begin
          pix_x_r <= sum_x[PIX_W-1:0];
          pix_y_r <= sum_y[PIX_W-1:0];
          last_r  <= (emit_idx_r == 2'd3);
          fin_r   <= (pos_y_r == '0);
        end
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_pixel_x  = pix_x_r;
  assign out_pixel_y  = pix_y_r;
  assign out_last     = last_r;
  assign out_finished = fin_r;

endmodule

`default_nettype wire

// File: src/ellipse_midpoint_rasterizer.sv
// Midpoint ellipse rasterizer, four-way symmetric, two regions. A start
// transaction (mode 0) loads the semi-axes and yields the four pixels at
// (0, b); each advance transaction (mode 1) runs one midpoint step and yields
// four pixels, last marking the fourth and finished marking the step that
// reaches y = 0; advances while no ellipse is active are dropped. The center
// comes from the center_x (0x0) and center_y (0x4) registers; write them only
// while the block is idle. A front stage and a two-entry command queue take
// transactions while the back end works. The back end shares one multiplier:
// a start computes aa, bb, aa*b and the first decision value in turn, an
// ordinary step forms aa*y and bb*x and then updates, the step that enters
// region two first rebuilds the decision value, and the four pixels then leave
// through the output register at one per cycle while the output is not stalled.
`default_nettype none

module ellipse_midpoint_rasterizer
  import emr_pkg::*;
#(
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_mode,
  input  wire logic [AXIS_WIDTH-1:0]  in_semi_axis_x,
  input  wire logic [AXIS_WIDTH-1:0]  in_semi_axis_y,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [PIX_W-1:0]     out_pixel_x,
  output logic signed [PIX_W-1:0]     out_pixel_y,
  output logic                        out_last,
  output logic                        out_finished,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  paddr,
  input  wire logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]       prdata,
  output logic                        pready
);

  localparam int CMD_W = 2*AXIS_WIDTH + 1;

  logic [CENTER_W-1:0] center_x_r;
  logic [CENTER_W-1:0] center_y_r;
  logic                cfg_we;
  reg_idx_t            cfg_idx;

  q_status_t           q_status;
  logic                q_push;
  logic                q_pop;
  logic [CMD_W-1:0]    q_wr_data;
  logic [CMD_W-1:0]    q_rd_data;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_we  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CENTER_X: center_x_r <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y: center_y_r <= pwdata[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER_X: prdata = CFG_DATA_W'(center_x_r);
      REG_CENTER_Y: prdata = CFG_DATA_W'(center_y_r);
      default:      prdata = '0;
    endcase
  end

  emr_front #(
    .AXIS_W (AXIS_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_semi_axis_x (in_semi_axis_x),
    .in_semi_axis_y (in_semi_axis_y),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_data         (q_wr_data)
  );

  emr_queue #(
    .DATA_W (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .status    (q_status)
  );

  emr_back #(
    .AXIS_W (AXIS_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_status     (q_status),
    .q_pop        (q_pop),
    .q_data       (q_rd_data),
    .center_x     (center_x_r),
    .center_y     (center_y_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel_x  (out_pixel_x),
    .out_pixel_y  (out_pixel_y),
    .out_last     (out_last),
    .out_finished (out_finished)
  );

endmodule

`default_nettype wire
